// ----- sv/pngunf_pkg.sv -----
// shared types and constants for the png scanline unfilter
`timescale 1ns / 1ps

package pngunf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIDTH_W = 14;  // line_width_pixels register
  localparam int unsigned PIX_W   = 4;   // bytes_per_pixel register
  localparam int unsigned LEN_W   = WIDTH_W + PIX_W;
  localparam int unsigned CFG_W   = WIDTH_W;

  // configuration register indexes
  localparam logic CFG_LINE_WIDTH  = 1'b0;
  localparam logic CFG_PIXEL_BYTES = 1'b1;

  typedef enum logic [BYTE_W-1:0] {
    FILT_NONE  = 8'd0,
    FILT_SUB   = 8'd1,
    FILT_UP    = 8'd2,
    FILT_AVG   = 8'd3,
    FILT_PAETH = 8'd4
  } filter_e;

  typedef struct packed {
    logic              bad_filter;
    logic              last_of_row;
    logic [BYTE_W-1:0] out_byte;
  } res_t;

endpackage

// ----- sv/pngunf_line_store.sv -----
// previous-row line store with registered read and write forwarding
`timescale 1ns / 1ps

module pngunf_line_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [pngunf_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [pngunf_pkg::BYTE_W-1:0] rdata_o
);
  import pngunf_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] mem_rd_q;
  logic              fwd_q;
  logic [BYTE_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[raddr_i];
  end

  // same-address write wins over the stale array read
  always_ff @(posedge clk_i) begin
    fwd_q      <= we_i && (waddr_i == raddr_i);
    fwd_data_q <= wdata_i;
  end

  assign rdata_o = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

// ----- sv/pngunf_recon.sv -----
// filter type decode and byte reconstruction (none, sub, up, average, paeth)
`timescale 1ns / 1ps

module pngunf_recon (
  input  logic [pngunf_pkg::BYTE_W-1:0] filter_i,
  input  logic [pngunf_pkg::BYTE_W-1:0] x_i,
  input  logic [pngunf_pkg::BYTE_W-1:0] a_i,
  input  logic [pngunf_pkg::BYTE_W-1:0] b_i,
  input  logic [pngunf_pkg::BYTE_W-1:0] c_i,
  output logic [pngunf_pkg::BYTE_W-1:0] r_o,
  output logic                          bad_o
);
  import pngunf_pkg::*;

  logic signed [BYTE_W+1:0] p, pa, pb, pc;
  logic [BYTE_W:0]          ab_sum;
  logic [BYTE_W-1:0]        avg;
  logic [BYTE_W-1:0]        paeth;

  always_comb begin
    p  = $signed({2'b00, a_i}) + $signed({2'b00, b_i}) - $signed({2'b00, c_i});
    pa = p - $signed({2'b00, a_i});
    pb = p - $signed({2'b00, b_i});
    pc = p - $signed({2'b00, c_i});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      paeth = a_i;
    end else if (pb <= pc) begin
      paeth = b_i;
    end else begin
      paeth = c_i;
    end
  end

  assign ab_sum = {1'b0, a_i} + {1'b0, b_i};
  assign avg    = ab_sum[BYTE_W:1];

  always_comb begin
    bad_o = 1'b0;
    case (filter_i)
      FILT_NONE:  r_o = x_i;
      FILT_SUB:   r_o = x_i + a_i;
      FILT_UP:    r_o = x_i + b_i;
      FILT_AVG:   r_o = x_i + avg;
      FILT_PAETH: r_o = x_i + paeth;
      default: begin
        r_o   = x_i;
        bad_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/pngunf_slot_calc.sv -----
// bit-serial column modulo pixel size, rerun after each register write
`timescale 1ns / 1ps

module pngunf_slot_calc #(
  parameter int unsigned CW = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CW-1:0]                col_i,
  input  logic [pngunf_pkg::PIX_W-1:0] pix_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [pngunf_pkg::PIX_W-1:0] rem_o
);
  import pngunf_pkg::*;

  localparam int unsigned BW = (CW > 1) ? $clog2(CW) : 1;

  logic             busy_q, busy_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [PIX_W-1:0] rem_q, rem_d;
  logic [PIX_W-1:0] rem_sh;

  // restoring remainder, one column bit per cycle from the top
  always_comb begin
    rem_sh = {rem_q[PIX_W-2:0], col_i[bit_q]};
    if (rem_sh >= pix_i) begin
      rem_sh = rem_sh - pix_i;
    end
  end

  always_comb begin
    busy_d = busy_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BW'(CW - 1);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_sh;
      bit_d = bit_q - 1'b1;
      if (bit_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (bit_q == '0) && !start_i;
  assign rem_o  = rem_sh;

endmodule

// ----- sv/pngunf_out_buf.sv -----
// two-entry result buffer between the reconstruction and the output stream
`timescale 1ns / 1ps

module pngunf_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pngunf_pkg::res_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pngunf_pkg::res_t   out_data_o
);
  import pngunf_pkg::*;

  res_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

// ----- sv/png_scanline_unfilter.sv -----
// top level of the png scanline unfilter (filter method 0 reconstruction)
//
//   port group   | direction | item contents
//   s_axis_*     | in        | tdata: filtered byte; tuser: start of image
//   m_axis_*     | out       | tdata: reconstructed byte; tlast: end of row; tuser: bad filter
//   cfg_*        | in        | addr 0: line width in pixels, addr 1: bytes per pixel
//
// one input byte per cycle while s_axis_tready is high; a result is written to the output
// buffer as its byte is taken. a filter type byte makes no result. the previous row comes
// from a line store with one read and one write port whose read address runs one byte
// ahead of the stream. after a register write the pixel slot is recomputed bit-serially,
// with s_axis_tready low while it runs. no clearing pass: the line store is undefined until
// written. a full output buffer (two items) holds s_axis_tready low.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
  parameter int unsigned MAX_LINE_BYTES  = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pngunf_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] start_of_image
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pngunf_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,  // [0] bad_filter
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_addr_i,
  input  logic [pngunf_pkg::CFG_W-1:0]  cfg_data_i
);
  import pngunf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINE_BYTES);
  localparam int unsigned SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // configuration
  logic [WIDTH_W-1:0] width_q;
  logic [PIX_W-1:0]   pix_reg_q;
  logic               cfg_we;
  logic [PIX_W-1:0]   pix;
  logic [WIDTH_W-1:0] width_eff;
  logic [LEN_W-1:0]   prod, line_len;

  // row state
  logic [CW-1:0]     col_q, col_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [BYTE_W-1:0] filter_q, filter_d;
  logic              first_row_q, first_row_d;
  logic              expect_type_q, expect_type_d;
  logic [BYTE_W-1:0] left_q   [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_q [MAX_PIXEL_BYTES];

  logic              in_accept, is_type, data_acc;
  logic [LEN_W-1:0]  col_next;
  logic              last, have_left;
  logic [BYTE_W-1:0] a_byte, b_byte, c_byte, up_byte, r_byte;
  logic              bad;
  logic              buf_ready;
  logic              calc_busy, calc_done;
  logic [PIX_W-1:0]  calc_rem;
  res_t              res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_W'(1);
      pix_reg_q <= PIX_W'(1);
    end else if (cfg_we) begin
      if (cfg_addr_i == CFG_LINE_WIDTH) begin
        width_q <= cfg_data_i[WIDTH_W-1:0];
      end else if (cfg_addr_i == CFG_PIXEL_BYTES) begin
        pix_reg_q <= cfg_data_i[PIX_W-1:0];
      end
    end
  end

  // zero counts as one, pixel size and line length clamp to the maximum
  always_comb begin
    pix = pix_reg_q;
    if (pix == '0) pix = PIX_W'(1);
    if (pix > PIX_W'(MAX_PIXEL_BYTES)) pix = PIX_W'(MAX_PIXEL_BYTES);
    width_eff = (width_q == '0) ? WIDTH_W'(1) : width_q;
    prod      = LEN_W'(width_eff) * LEN_W'(pix);
    line_len  = (prod > LEN_W'(MAX_LINE_BYTES)) ? LEN_W'(MAX_LINE_BYTES) : prod;
  end

  assign s_axis_tready = buf_ready && !calc_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_type       = s_axis_tuser || expect_type_q;
  assign data_acc      = in_accept && !is_type;

  assign col_next  = LEN_W'(col_q) + LEN_W'(1);
  assign last      = (col_next >= line_len);
  assign have_left = (LEN_W'(col_q) >= LEN_W'(pix));

  assign a_byte = have_left ? left_q[slot_q] : '0;
  assign b_byte = first_row_q ? '0 : up_byte;
  assign c_byte = (have_left && !first_row_q) ? upleft_q[slot_q] : '0;

  pngunf_recon u_recon (
    .filter_i (filter_q),
    .x_i      (s_axis_tdata),
    .a_i      (a_byte),
    .b_i      (b_byte),
    .c_i      (c_byte),
    .r_o      (r_byte),
    .bad_o    (bad)
  );

  always_comb begin
    col_d         = col_q;
    slot_d        = slot_q;
    filter_d      = filter_q;
    first_row_d   = first_row_q;
    expect_type_d = expect_type_q;
    if (calc_done) begin
      slot_d = calc_rem[SW-1:0];
    end
    if (in_accept) begin
      if (is_type) begin
        filter_d      = s_axis_tdata;
        expect_type_d = 1'b0;
        col_d         = '0;
        slot_d        = '0;
        if (s_axis_tuser) first_row_d = 1'b1;
      end else if (last) begin
        col_d         = '0;
        slot_d        = '0;
        expect_type_d = 1'b1;
        first_row_d   = 1'b0;
      end else begin
        col_d  = col_next[CW-1:0];
        slot_d = (PIX_W'(slot_q) + PIX_W'(1) == pix) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      slot_q        <= '0;
      filter_q      <= '0;
      first_row_q   <= 1'b1;
      expect_type_q <= 1'b1;
    end else begin
      col_q         <= col_d;
      slot_q        <= slot_d;
      filter_q      <= filter_d;
      first_row_q   <= first_row_d;
      expect_type_q <= expect_type_d;
    end
  end

  // current pixel and the previous-row pixel before it, one byte per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i]   <= '0;
        upleft_q[i] <= '0;
      end
    end else if (data_acc) begin
      left_q[slot_q]   <= r_byte;
      upleft_q[slot_q] <= b_byte;
    end
  end

  // read address follows the next column so the up byte is ready in time
  pngunf_line_store #(
    .DEPTH (MAX_LINE_BYTES),
    .AW    (CW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (data_acc),
    .waddr_i (col_q),
    .wdata_i (r_byte),
    .raddr_i (col_d),
    .rdata_o (up_byte)
  );

  pngunf_slot_calc #(
    .CW (CW)
  ) u_slot_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we),
    .col_i   (col_q),
    .pix_i   (pix),
    .busy_o  (calc_busy),
    .done_o  (calc_done),
    .rem_o   (calc_rem)
  );

  assign res_in.out_byte    = r_byte;
  assign res_in.last_of_row = last;
  assign res_in.bad_filter  = bad;

  pngunf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (data_acc),
    .in_ready_o  (buf_ready),
    .in_data_i   (res_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata = res_out.out_byte;
  assign m_axis_tlast = res_out.last_of_row;
  assign m_axis_tuser = res_out.bad_filter;

endmodule
